/* hw/rtl/bts_pkg.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared widths, codes and types of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int COORD_W     = 17;
  localparam int ADDR_W      = 16;
  localparam int SIZE_W      = 9;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int TEXEL_W     = NUM_CHAN * CHAN_W;
  localparam int OUT_W       = 16;
  localparam int STORE_DEPTH = 65536;

  // Input transaction kinds.
  localparam logic KIND_WRITE = 1'b0;

  // Configuration register indexes.
  localparam logic CFG_TEX_WIDTH  = 1'b0;
  localparam logic CFG_TEX_HEIGHT = 1'b1;

  // Corner order of a bilinear fetch: bit 0 picks x1, bit 1 picks y1.
  typedef logic [1:0] step_t;
  localparam step_t CORNER_FIRST = 2'd0;
  localparam step_t CORNER_LAST  = 2'd3;

  typedef logic [NUM_CHAN*OUT_W-1:0] color_t;

endpackage

/* hw/rtl/bilinear_texture_sampler_unit.sv */
// ----------------------------------------------------------------------------
// Bilinear texture sampler unit
// RGB texel store with nearest and bilinear sampling.
// ----------------------------------------------------------------------------
// The texture lives in one single-port 65536 x 24 memory with a registered
// read. A write transaction or a nearest sample makes one texel access and a
// bilinear sample makes four, one texel read per cycle, so the memory port
// sets the rate: one write or nearest sample per cycle while no bilinear
// sample is reading (a sample waits while the result queue lacks room for
// its result). A result enters the result queue when the registered read of
// its last texel returns. A one-entry input buffer takes the next transaction
// while the current one is still reading, and a two-entry result queue
// decouples the output. Colors are unnormalized: each channel is byte times
// 256 at full weight. The memory has no reset; sampling a texel that was
// never written returns undefined data.
module bilinear_texture_sampler_unit import bts_pkg::*; #(
  parameter int MAX_DIM         = 256,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [SIZE_W-1:0]         cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [ADDR_W-1:0]         in_texel_index,
  input  logic [CHAN_W-1:0]         in_red_in,
  input  logic [CHAN_W-1:0]         in_green_in,
  input  logic [CHAN_W-1:0]         in_blue_in,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic                      in_bilinear,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_W-1:0]          out_red_out,
  output logic [OUT_W-1:0]          out_green_out,
  output logic [OUT_W-1:0]          out_blue_out
);

  localparam int FRAC_W  = COORD_FRAC_BITS;
  localparam int IPART_W = COORD_W - FRAC_W;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CMP_W   = (SIZE_W > DIM_W) ? SIZE_W : DIM_W;
  localparam int CL_W    = (IPART_W + 1 > SIZE_W + 1) ? IPART_W + 1 : SIZE_W + 1;
  localparam int WGT_W   = 2 * FRAC_W + 1;
  localparam int PROD_W  = CHAN_W + WGT_W;
  localparam int ACC_W   = 2 * FRAC_W + 8;
  localparam int OUT_LSB = 2 * FRAC_W - 8;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(reg_val);
    if (reg_val == '0) begin
      eff_size = SIZE_W'(1);
    end else if (ext > CMP_W'(MAX_DIM)) begin
      eff_size = SIZE_W'(MAX_DIM);
    end else begin
      eff_size = reg_val;
    end
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_axis(input logic signed [IPART_W:0] v,
                                                   input logic [SIZE_W-1:0] size);
    logic [CL_W-1:0] vext;
    logic [CL_W-1:0] lim;
    vext = CL_W'(v);
    lim  = CL_W'(size) - CL_W'(1);
    if (v[IPART_W]) begin
      clamp_axis = '0;
    end else if (vext > lim) begin
      clamp_axis = size - SIZE_W'(1);
    end else begin
      clamp_axis = vext[SIZE_W-1:0];
    end
  endfunction

  // Configuration registers.
  logic [SIZE_W-1:0] tex_width_r;
  logic [SIZE_W-1:0] tex_height_r;
  logic [SIZE_W-1:0] eff_w;
  logic [SIZE_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SIZE_W'(1);
      tex_height_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        CFG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default:        tex_width_r  <= tex_width_r;
      endcase
    end
  end

  assign eff_w = eff_size(tex_width_r);
  assign eff_h = eff_size(tex_height_r);

  // Coordinate split and edge clamping at the input.
  logic signed [IPART_W:0] ix0;
  logic signed [IPART_W:0] ix1;
  logic signed [IPART_W:0] iy0;
  logic signed [IPART_W:0] iy1;

  assign ix0 = {in_coord_x[COORD_W-1], in_coord_x[COORD_W-1:FRAC_W]};
  assign iy0 = {in_coord_y[COORD_W-1], in_coord_y[COORD_W-1:FRAC_W]};
  assign ix1 = ix0 + (IPART_W+1)'(1);
  assign iy1 = iy0 + (IPART_W+1)'(1);

  // Input buffer.
  logic               buf_valid_r;
  logic               buf_kind_r;
  logic               buf_bilinear_r;
  logic [ADDR_W-1:0]  buf_waddr_r;
  logic [TEXEL_W-1:0] buf_wdata_r;
  logic [SIZE_W-1:0]  buf_x0_r;
  logic [SIZE_W-1:0]  buf_x1_r;
  logic [SIZE_W-1:0]  buf_y0_r;
  logic [SIZE_W-1:0]  buf_y1_r;
  logic [FRAC_W-1:0]  buf_fx_r;
  logic [FRAC_W-1:0]  buf_fy_r;
  logic               buf_take;
  logic               in_accept;

  assign in_ready  = !buf_valid_r || buf_take;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else if (in_accept) begin
      buf_valid_r <= 1'b1;
    end else if (buf_take) begin
      buf_valid_r <= 1'b0;
    end
  end

  // A nearest sample is a bilinear read of one corner at zero fraction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      buf_kind_r     <= in_kind;
      buf_bilinear_r <= in_bilinear;
      buf_waddr_r    <= in_texel_index;
      buf_wdata_r    <= {in_red_in, in_green_in, in_blue_in};
      buf_x0_r       <= clamp_axis(ix0, eff_w);
      buf_x1_r       <= clamp_axis(ix1, eff_w);
      buf_y0_r       <= clamp_axis(iy0, eff_h);
      buf_y1_r       <= clamp_axis(iy1, eff_h);
      buf_fx_r       <= in_bilinear ? in_coord_x[FRAC_W-1:0] : '0;
      buf_fy_r       <= in_bilinear ? in_coord_y[FRAC_W-1:0] : '0;
    end
  end

  // Read sequencer.
  logic              seq_busy_r;
  step_t             step_r;
  logic [SIZE_W-1:0] cur_x0_r;
  logic [SIZE_W-1:0] cur_x1_r;
  logic [SIZE_W-1:0] cur_y0_r;
  logic [SIZE_W-1:0] cur_y1_r;
  logic [FRAC_W-1:0] cur_fx_r;
  logic [FRAC_W-1:0] cur_fy_r;
  logic              inflight_r;
  logic [1:0]        cnt_r;
  logic              credit_ok;
  logic              load_cur;
  logic              iss_rd;
  logic              ram_we;
  logic              iss_first;
  logic              iss_last;
  step_t             iss_step;
  logic [SIZE_W-1:0] iss_x;
  logic [SIZE_W-1:0] iss_y;
  logic [FRAC_W-1:0] iss_fx;
  logic [FRAC_W-1:0] iss_fy;
  logic [FRAC_W:0]   iss_wx;
  logic [FRAC_W:0]   iss_wy;
  logic [2*FRAC_W+1:0] iss_wprod;
  logic [2*SIZE_W-1:0] row_off;
  logic [2*SIZE_W-1:0] lin_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic [TEXEL_W-1:0] ram_rdata;

  // Room in the result queue for the sample in flight and the one to start.
  assign credit_ok = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !inflight_r);

  always_comb begin
    buf_take = 1'b0;
    ram_we   = 1'b0;
    iss_rd   = 1'b0;
    load_cur = 1'b0;
    if (seq_busy_r) begin
      iss_rd = 1'b1;
    end else if (buf_valid_r) begin
      if (buf_kind_r == KIND_WRITE) begin
        ram_we   = 1'b1;
        buf_take = 1'b1;
      end else if (credit_ok) begin
        iss_rd   = 1'b1;
        buf_take = 1'b1;
        load_cur = 1'b1;
      end
    end
  end

  assign iss_first = !seq_busy_r;
  assign iss_step  = seq_busy_r ? step_r : CORNER_FIRST;
  assign iss_last  = seq_busy_r ? (step_r == CORNER_LAST) : !buf_bilinear_r;
  assign iss_x  = iss_step[0] ? (seq_busy_r ? cur_x1_r : buf_x1_r)
                              : (seq_busy_r ? cur_x0_r : buf_x0_r);
  assign iss_y  = iss_step[1] ? (seq_busy_r ? cur_y1_r : buf_y1_r)
                              : (seq_busy_r ? cur_y0_r : buf_y0_r);
  assign iss_fx = seq_busy_r ? cur_fx_r : buf_fx_r;
  assign iss_fy = seq_busy_r ? cur_fy_r : buf_fy_r;

  assign iss_wx = iss_step[0] ? {1'b0, iss_fx} : ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, iss_fx};
  assign iss_wy = iss_step[1] ? {1'b0, iss_fy} : ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, iss_fy};
  assign iss_wprod = iss_wx * iss_wy;

  assign row_off  = iss_y * eff_w;
  assign lin_addr = row_off + (2*SIZE_W)'(iss_x);
  assign ram_addr = ram_we ? buf_waddr_r : lin_addr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_busy_r <= 1'b0;
      step_r     <= CORNER_FIRST;
    end else if (seq_busy_r) begin
      step_r <= step_r + step_t'(1);
      if (step_r == CORNER_LAST) begin
        seq_busy_r <= 1'b0;
      end
    end else if (load_cur && buf_bilinear_r) begin
      seq_busy_r <= 1'b1;
      step_r     <= CORNER_FIRST + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_x0_r <= buf_x0_r;
      cur_x1_r <= buf_x1_r;
      cur_y0_r <= buf_y0_r;
      cur_y1_r <= buf_y1_r;
      cur_fx_r <= buf_fx_r;
      cur_fy_r <= buf_fy_r;
    end
  end

  bts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_texel_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (buf_wdata_r),
    .rdata (ram_rdata)
  );

  // Blend stage: texel data returns from the registered read in the cycle after the read is issued.
  logic             rd_valid_r;
  logic             rd_first_r;
  logic             rd_last_r;
  logic [WGT_W-1:0] rd_weight_r;
  logic             push;
  color_t           push_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= iss_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r  <= iss_first;
    rd_last_r   <= iss_last;
    rd_weight_r <= iss_wprod[WGT_W-1:0];
  end

  assign push = rd_valid_r && rd_last_r;

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    logic [CHAN_W-1:0] byte_val;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_r;
    logic [ACC_W-1:0]  acc_nxt;

    assign byte_val = ram_rdata[TEXEL_W-CHAN_W*(ch+1) +: CHAN_W];
    assign prod     = byte_val * rd_weight_r;
    assign acc_nxt  = (rd_first_r ? '0 : acc_r) + prod[ACC_W-1:0];
    assign push_data[(NUM_CHAN-1-ch)*OUT_W +: OUT_W] = acc_nxt[OUT_LSB +: OUT_W];

    always_ff @(posedge clk) begin
      if (rd_valid_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
    end else if (load_cur) begin
      inflight_r <= 1'b1;
    end else if (push) begin
      inflight_r <= 1'b0;
    end
  end

  // Two-entry result queue.
  color_t head_r;
  color_t tail_r;
  logic   pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == 2'd0) begin
      if (push) begin
        head_r <= push_data;
      end
    end else if (pop) begin
      head_r <= (cnt_r == 2'd2) ? tail_r : push_data;
    end
    if (push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop))) begin
      tail_r <= push_data;
    end
  end

  assign out_red_out   = head_r[2*OUT_W +: OUT_W];
  assign out_green_out = head_r[OUT_W +: OUT_W];
  assign out_blue_out  = head_r[0 +: OUT_W];

endmodule

/* hw/rtl/bts_ram.sv */
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one address port and a registered read.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
